@@ sv/dmrh_pkg.sv @@
// ----------------------------------------------------------------------------
// dmrh_pkg
// Shared types, constants and modular helpers for the double modulus
// rolling hash: item and result formats, the command format passed from the
// front end to the back end, and the per-modulus constants.
// ----------------------------------------------------------------------------
package dmrh_pkg;

    // Lane 0 works modulo the first prime, lane 1 modulo the second.
    localparam int unsigned LANES      = 2;
    localparam int unsigned VAL_W      = 30;
    localparam int unsigned LEN_W      = 17;
    localparam int unsigned MU_W       = 31;

    localparam logic [VAL_W-1:0] PRIME_A = 30'd1000000033;
    localparam logic [VAL_W-1:0] PRIME_B = 30'd1000000007;

    // Barrett factors floor(2^60 / prime).
    localparam logic [MU_W-1:0] MU_A = MU_W'((64'd1 << 60) / 64'd1000000033);
    localparam logic [MU_W-1:0] MU_B = MU_W'((64'd1 << 60) / 64'd1000000007);

    // Modular inverses of the base: 31 * INV = 1 modulo each prime.
    localparam logic [VAL_W-1:0] INV_A = 30'd387096787;
    localparam logic [VAL_W-1:0] INV_B = 30'd129032259;

    localparam logic [VAL_W-1:0] HASH_BASE = 30'd31;
    localparam logic [7:0]       SYM_OFFSET = 8'd96;

    // Largest window length accepted before adds are refused.
    localparam logic [LEN_W-1:0] MAX_LEN = 17'd65536;

    localparam logic [LANES-1:0][VAL_W-1:0] PRIMES   = {PRIME_B, PRIME_A};
    localparam logic [LANES-1:0][MU_W-1:0]  MUS      = {MU_B, MU_A};
    localparam logic [LANES-1:0][VAL_W-1:0] INVERSES = {INV_B, INV_A};

    // Depth of the command queue between front and back end.
    localparam int unsigned CMD_DEPTH = 2;

    // Operation codes carried in the kind field of an input item.
    localparam logic [2:0] KIND_ADD_BACK  = 3'd0;
    localparam logic [2:0] KIND_ADD_FRONT = 3'd1;
    localparam logic [2:0] KIND_REM_BACK  = 3'd2;
    localparam logic [2:0] KIND_REM_FRONT = 3'd3;
    localparam logic [2:0] KIND_CLEAR     = 3'd4;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] symbol;
    } in_item_t;

    typedef struct packed {
        logic [VAL_W-1:0] hash_first;
        logic [VAL_W-1:0] hash_second;
        logic [LEN_W-1:0] length;
        logic             refused;
    } out_item_t;

    // Command for the back end after classification.
    typedef enum logic [2:0] {
        CMD_ADD_BACK,
        CMD_ADD_FRONT,
        CMD_REM_BACK,
        CMD_REM_FRONT,
        CMD_CLEAR,
        CMD_HOLD
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t                     op;
        logic [LANES-1:0][VAL_W-1:0] value;
        logic [LEN_W-1:0]            length;
        logic                        refused;
    } cmd_t;

    // Symbol byte minus the offset, reduced modulo p.
    function automatic logic [VAL_W-1:0] sym_value(input logic [7:0] sym,
                                                   input logic [VAL_W-1:0] p);
        logic [VAL_W-1:0] s;
        s = {22'd0, sym};
        if (sym >= SYM_OFFSET)
            return s - {22'd0, SYM_OFFSET};
        else
            return s + (p - {22'd0, SYM_OFFSET});
    endfunction

    // (x + y) mod p for x, y below p.
    function automatic logic [VAL_W-1:0] add_mod(input logic [VAL_W-1:0] x,
                                                 input logic [VAL_W-1:0] y,
                                                 input logic [VAL_W-1:0] p);
        logic [VAL_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, p})
            s = s - {1'b0, p};
        return s[VAL_W-1:0];
    endfunction

    // (x - y) mod p for x, y below p.
    function automatic logic [VAL_W-1:0] sub_mod(input logic [VAL_W-1:0] x,
                                                 input logic [VAL_W-1:0] y,
                                                 input logic [VAL_W-1:0] p);
        if (x >= y)
            return x - y;
        else
            return x + (p - y);
    endfunction

endpackage

@@ sv/dmrh_front.sv @@
// ----------------------------------------------------------------------------
// dmrh_front
// Front end: accepts items, keeps a shadow of the window length, decides
// refusals and converts the symbol into its value modulo each prime.
// ----------------------------------------------------------------------------
module dmrh_front
    import dmrh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t item,
    output logic     q_push,
    output cmd_t     q_data,
    input  logic     q_full
);

    logic [LEN_W-1:0] length_reg;
    logic [LEN_W-1:0] length_next;

    // The front stalls only when the command queue is full.
    assign full   = q_full;
    assign q_push = push & ~q_full;

    // Classify the item and work out the window length after it.
    always_comb
    begin
        q_data.refused = 1'b0;
        q_data.length  = length_reg;
        q_data.op      = CMD_HOLD;
        for (int l = 0; l < LANES; l++)
        begin
            q_data.value[l] = sym_value(item.symbol, PRIMES[l]);
        end
        case (item.kind)
            KIND_ADD_BACK, KIND_ADD_FRONT:
            begin
                if (length_reg >= MAX_LEN)
                begin
                    q_data.refused = 1'b1;
                end
                else
                begin
                    q_data.op     = (item.kind == KIND_ADD_BACK) ? CMD_ADD_BACK
                                                                 : CMD_ADD_FRONT;
                    q_data.length = length_reg + 1'b1;
                end
            end
            KIND_REM_BACK, KIND_REM_FRONT:
            begin
                if (length_reg == '0)
                begin
                    q_data.refused = 1'b1;
                end
                else
                begin
                    q_data.op     = (item.kind == KIND_REM_BACK) ? CMD_REM_BACK
                                                                 : CMD_REM_FRONT;
                    q_data.length = length_reg - 1'b1;
                end
            end
            KIND_CLEAR:
            begin
                q_data.op     = CMD_CLEAR;
                q_data.length = '0;
            end
            default:
            begin
                q_data.op = CMD_HOLD;
            end
        endcase
        length_next = q_push ? q_data.length : length_reg;
    end

    // Length shadow register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            length_reg <= '0;
        else
            length_reg <= length_next;
    end

endmodule

@@ sv/dmrh_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// dmrh_cmd_queue
// Short first-in first-out queue of commands between the front end and the
// back end, so that either side can stall on its own.
// ----------------------------------------------------------------------------
module dmrh_cmd_queue
    import dmrh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t data_in,
    output logic full,
    input  logic pop,
    output cmd_t data_out,
    output logic empty
);

    localparam int unsigned PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(CMD_DEPTH + 1);

    cmd_t             entry_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(CMD_DEPTH));
    assign empty    = (count_reg == '0);
    assign data_out = entry_reg[rd_ptr_reg];
    assign do_push  = push & ~full;
    assign do_pop   = pop & ~empty;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage; payload only, no reset needed.
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= data_in;
    end

endmodule

@@ sv/dmrh_modmul.sv @@
// ----------------------------------------------------------------------------
// dmrh_modmul
// Pipelined Barrett modular multiplier: r = a * b mod p for a, b below p,
// with p a 30-bit modulus and mu = floor(2^60 / p). Registered stages:
// operands, product, quotient estimate, remainder, corrected result.
// ----------------------------------------------------------------------------
module dmrh_modmul
    import dmrh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [VAL_W-1:0] a,
    input  logic [VAL_W-1:0] b,
    input  logic [VAL_W-1:0] p,
    input  logic [MU_W-1:0]  mu,
    output logic             done,
    output logic [VAL_W-1:0] r
);

    logic [4:0]             vld_reg;
    logic [VAL_W-1:0]       a_reg;
    logic [VAL_W-1:0]       b_reg;
    logic [2*VAL_W-1:0]     x_reg;
    logic [2*MU_W-1:0]      t_reg;
    logic [31:0]            xl_reg;
    logic [31:0]            rem_reg;
    logic [VAL_W-1:0]       res_reg;
    logic [MU_W+VAL_W-1:0]  qp;
    logic [31:0]            rem_red;
    logic [31:0]            p_ext;
    logic [31:0]            p2_ext;

    assign done = vld_reg[4];
    assign r    = res_reg;

    // Estimated quotient times modulus; only the low 32 bits matter since
    // the remainder stays below three times the modulus.
    assign qp     = t_reg[2*MU_W-1:MU_W] * p;
    assign p_ext  = {2'b00, p};
    assign p2_ext = {1'b0, p, 1'b0};

    // Final correction: at most two subtractions of the modulus.
    always_comb
    begin
        if (rem_reg >= p2_ext)
            rem_red = rem_reg - p2_ext;
        else if (rem_reg >= p_ext)
            rem_red = rem_reg - p_ext;
        else
            rem_red = rem_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[3:0], start};
    end

    // Datapath stages.
    always_ff @(posedge clk)
    begin
        a_reg   <= a;
        b_reg   <= b;
        x_reg   <= a_reg * b_reg;
        t_reg   <= x_reg[2*VAL_W-1:VAL_W-1] * mu;
        xl_reg  <= x_reg[31:0];
        rem_reg <= xl_reg - qp[31:0];
        res_reg <= rem_red[VAL_W-1:0];
    end

endmodule

@@ sv/dmrh_back.sv @@
// ----------------------------------------------------------------------------
// dmrh_back
// Back end: takes commands from the queue and, for adds and removes, updates
// the hash and base power of both moduli with two passes through a modular
// multiplier per lane (clear resets them), then loads the output register.
// ----------------------------------------------------------------------------
module dmrh_back
    import dmrh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  cmd_t      q_data,
    output logic      q_pop,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_WAIT1,
        ST_MUL2,
        ST_WAIT2,
        ST_OUT
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    cmd_t                        cmd_reg;
    cmd_t                        cmd_next;
    logic [LANES-1:0][VAL_W-1:0] hash_reg;
    logic [LANES-1:0][VAL_W-1:0] hash_next;
    logic [LANES-1:0][VAL_W-1:0] power_reg;
    logic [LANES-1:0][VAL_W-1:0] power_next;
    out_item_t                   out_reg;
    out_item_t                   out_next;
    logic                        out_vld_reg;
    logic                        out_vld_next;

    logic                        mul_start;
    logic [LANES-1:0][VAL_W-1:0] mul_a;
    logic [LANES-1:0][VAL_W-1:0] mul_b;
    logic [LANES-1:0]            mul_done;
    logic [LANES-1:0][VAL_W-1:0] mul_r;

    assign empty  = ~out_vld_reg;
    assign result = out_reg;

    // One modular multiplier per modulus.
    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        dmrh_modmul u_modmul (
            .clk   (clk),
            .rst_n (rst_n),
            .start (mul_start),
            .a     (mul_a[l]),
            .b     (mul_b[l]),
            .p     (PRIMES[l]),
            .mu    (MUS[l]),
            .done  (mul_done[l]),
            .r     (mul_r[l])
        );
    end

    // Sequencer: for adds and removes, first multiplication, its update, second
    // multiplication, its update; every command ends with the result transfer.
    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        hash_next    = hash_reg;
        power_next   = power_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg & ~pop;
        q_pop        = 1'b0;
        mul_start    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_data;
                    case (q_data.op)
                        CMD_CLEAR:
                        begin
                            for (int l = 0; l < LANES; l++)
                            begin
                                hash_next[l]  = '0;
                                power_next[l] = VAL_W'(1);
                            end
                            state_next = ST_OUT;
                        end
                        CMD_HOLD:
                        begin
                            state_next = ST_OUT;
                        end
                        default:
                        begin
                            state_next = ST_MUL1;
                        end
                    endcase
                end
            end
            ST_MUL1:
            begin
                mul_start = 1'b1;
                for (int l = 0; l < LANES; l++)
                begin
                    case (cmd_reg.op)
                        CMD_ADD_BACK:
                        begin
                            mul_a[l] = cmd_reg.value[l];
                            mul_b[l] = power_reg[l];
                        end
                        CMD_ADD_FRONT:
                        begin
                            mul_a[l] = hash_reg[l];
                            mul_b[l] = HASH_BASE;
                        end
                        CMD_REM_BACK:
                        begin
                            mul_a[l] = power_reg[l];
                            mul_b[l] = INVERSES[l];
                        end
                        CMD_REM_FRONT:
                        begin
                            mul_a[l] = sub_mod(hash_reg[l], cmd_reg.value[l], PRIMES[l]);
                            mul_b[l] = INVERSES[l];
                        end
                        default:
                        begin
                            mul_a[l] = '0;
                            mul_b[l] = '0;
                        end
                    endcase
                end
                state_next = ST_WAIT1;
            end
            ST_WAIT1:
            begin
                if (mul_done[0])
                begin
                    for (int l = 0; l < LANES; l++)
                    begin
                        case (cmd_reg.op)
                            CMD_ADD_BACK:
                                hash_next[l] = add_mod(hash_reg[l], mul_r[l], PRIMES[l]);
                            CMD_ADD_FRONT:
                                hash_next[l] = add_mod(mul_r[l], cmd_reg.value[l],
                                                       PRIMES[l]);
                            CMD_REM_BACK:
                                power_next[l] = mul_r[l];
                            CMD_REM_FRONT:
                                hash_next[l] = mul_r[l];
                            default:
                                hash_next[l] = hash_reg[l];
                        endcase
                    end
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                mul_start = 1'b1;
                for (int l = 0; l < LANES; l++)
                begin
                    case (cmd_reg.op)
                        CMD_ADD_BACK, CMD_ADD_FRONT:
                        begin
                            mul_a[l] = power_reg[l];
                            mul_b[l] = HASH_BASE;
                        end
                        CMD_REM_BACK:
                        begin
                            // Power already stepped down to the removed position.
                            mul_a[l] = cmd_reg.value[l];
                            mul_b[l] = power_reg[l];
                        end
                        CMD_REM_FRONT:
                        begin
                            mul_a[l] = power_reg[l];
                            mul_b[l] = INVERSES[l];
                        end
                        default:
                        begin
                            mul_a[l] = '0;
                            mul_b[l] = '0;
                        end
                    endcase
                end
                state_next = ST_WAIT2;
            end
            ST_WAIT2:
            begin
                if (mul_done[0])
                begin
                    for (int l = 0; l < LANES; l++)
                    begin
                        case (cmd_reg.op)
                            CMD_REM_BACK:
                                hash_next[l] = sub_mod(hash_reg[l], mul_r[l], PRIMES[l]);
                            default:
                                power_next[l] = mul_r[l];
                        endcase
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Load the output register once the previous result is taken.
                if (!out_vld_reg || pop)
                begin
                    out_vld_next         = 1'b1;
                    out_next.hash_first  = hash_reg[0];
                    out_next.hash_second = hash_reg[1];
                    out_next.length      = cmd_reg.length;
                    out_next.refused     = cmd_reg.refused;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, window hash and power, and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
            for (int l = 0; l < LANES; l++)
            begin
                hash_reg[l]  <= '0;
                power_reg[l] <= VAL_W'(1);
            end
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            hash_reg    <= hash_next;
            power_reg   <= power_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

endmodule

@@ sv/double_modulus_rolling_hash.sv @@
// ----------------------------------------------------------------------------
// double_modulus_rolling_hash
// Adds and removes make two dependent passes through the 5-stage modular
// multiplier of each modulus; clear, refused items and unused kinds skip
// the multiplier. The back end works on one item at a time, and the
// command queue takes up to 2 further items meanwhile.
// Reset: asynchronous, active low; hashes and length to zero, powers to one.
// ----------------------------------------------------------------------------
module double_modulus_rolling_hash
    import dmrh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic q_push;
    cmd_t q_wdata;
    logic q_full;
    logic q_pop;
    cmd_t q_rdata;
    logic q_empty;

    // Front end: classification and length tracking.
    dmrh_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_push (q_push),
        .q_data (q_wdata),
        .q_full (q_full)
    );

    // Command queue between the two ends.
    dmrh_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .data_in  (q_wdata),
        .full     (q_full),
        .pop      (q_pop),
        .data_out (q_rdata),
        .empty    (q_empty)
    );

    // Back end: modular arithmetic and the output register.
    dmrh_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

@@ tb/double_modulus_rolling_hash_tb.sv @@
// ----------------------------------------------------------------------------
// double_modulus_rolling_hash_tb
// Self-checking testbench for the double modulus rolling hash. A driver takes
// symbol operations from a queue and pushes them into the block. Each
// transfer in is run through a local copy of the hash state, under both
// primes, to predict the result. A monitor pops results and compares every
// field with the oldest prediction. The stimulus has two parts: a short
// directed part and then random operation streams.
// ----------------------------------------------------------------------------
module double_modulus_rolling_hash_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dmrh_pkg::*;

    // Spare codes of the kind field.
    localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI  = 3'd7;

    localparam logic [7:0] LOWER_A = 8'd97;
    localparam logic [7:0] LOWER_Z = 8'd122;

    localparam longint unsigned MOD_A       = PRIME_A;
    localparam longint unsigned MOD_B       = PRIME_B;
    localparam longint unsigned RADIX       = HASH_BASE;
    localparam longint unsigned SYMBOL_BIAS = SYM_OFFSET;
    localparam int unsigned     WINDOW_CAP  = MAX_LEN;

    localparam int unsigned IDLE_PERCENT = 14;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned SETTLE_WAIT  = 20;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    in_item_t  item = '0;
    logic      empty;
    logic      pop = 1'b0;
    out_item_t result;

    // Operations waiting for the driver, and predicted results in order.
    in_item_t  queued_ops[$];
    out_item_t expected_hashes[$];

    // Symbols the window should hold, used to pick well-formed removals.
    logic [7:0] window_syms[$];

    // When set, neither side idles.
    bit quiet = 1'b0;

    // Predicted hash state under both primes.
    longint unsigned hash_a = 0;
    longint unsigned hash_b = 0;
    longint unsigned power_a = 1;
    longint unsigned power_b = 1;
    longint unsigned inv_a;
    longint unsigned inv_b;
    int unsigned     win_len = 0;

    int unsigned items_sent = 0;
    int unsigned results_checked = 0;
    int unsigned refusals = 0;
    int unsigned longest_window = 0;
    int unsigned mismatches = 0;
    int unsigned stall_cycles = 0;

    double_modulus_rolling_hash DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Modular exponentiation, used for the inverse of the base.
    function automatic longint unsigned pow_mod(input longint unsigned b,
                                                input longint unsigned e,
                                                input longint unsigned m);
        longint unsigned r = 1;
        b = b % m;
        while (e != 0)
        begin
            if (e[0])
                r = (r * b) % m;
            b = (b * b) % m;
            e = e >> 1;
        end
        return r;
    endfunction

    // Apply one accepted operation to the predicted state and queue the
    // result it must produce.
    task automatic roll_hashes(input in_item_t op);
        longint unsigned va;
        longint unsigned vb;
        logic            refused;
        va = (MOD_A + op.symbol - SYMBOL_BIAS) % MOD_A;
        vb = (MOD_B + op.symbol - SYMBOL_BIAS) % MOD_B;
        refused = 1'b0;
        case (op.kind)
            KIND_ADD_BACK, KIND_ADD_FRONT:
            begin
                if (win_len >= WINDOW_CAP)
                    refused = 1'b1;
                else
                begin
                    if (op.kind == KIND_ADD_BACK)
                    begin
                        hash_a = (hash_a + va * power_a) % MOD_A;
                        hash_b = (hash_b + vb * power_b) % MOD_B;
                    end
                    else
                    begin
                        hash_a = (hash_a * RADIX + va) % MOD_A;
                        hash_b = (hash_b * RADIX + vb) % MOD_B;
                    end
                    power_a = (power_a * RADIX) % MOD_A;
                    power_b = (power_b * RADIX) % MOD_B;
                    win_len++;
                end
            end
            KIND_REM_BACK, KIND_REM_FRONT:
            begin
                if (win_len == 0)
                    refused = 1'b1;
                else
                begin
                    power_a = (power_a * inv_a) % MOD_A;
                    power_b = (power_b * inv_b) % MOD_B;
                    // Back removal takes the symbol at the new top power;
                    // front removal strips position zero and shifts down.
                    if (op.kind == KIND_REM_BACK)
                    begin
                        hash_a = (hash_a + MOD_A - (va * power_a) % MOD_A) % MOD_A;
                        hash_b = (hash_b + MOD_B - (vb * power_b) % MOD_B) % MOD_B;
                    end
                    else
                    begin
                        hash_a = (((hash_a + MOD_A - va) % MOD_A) * inv_a) % MOD_A;
                        hash_b = (((hash_b + MOD_B - vb) % MOD_B) * inv_b) % MOD_B;
                    end
                    win_len--;
                end
            end
            KIND_CLEAR:
            begin
                hash_a = 0;
                hash_b = 0;
                power_a = 1;
                power_b = 1;
                win_len = 0;
            end
            default:
            begin
            end
        endcase
        if (refused)
            refusals++;
        if (win_len > longest_window)
            longest_window = win_len;
        expected_hashes.push_back(out_item_t'{
            hash_first:  VAL_W'(hash_a),
            hash_second: VAL_W'(hash_b),
            length:      LEN_W'(win_len),
            refused:     refused});
    endtask

    // Queue one operation and track what the window will hold after it.
    task automatic plan_op(input logic [2:0] kind, input logic [7:0] sym);
        queued_ops.push_back(in_item_t'{kind: kind, symbol: sym});
        case (kind)
            KIND_ADD_BACK:
                if (window_syms.size() < WINDOW_CAP)
                    window_syms.push_back(sym);
            KIND_ADD_FRONT:
                if (window_syms.size() < WINDOW_CAP)
                    window_syms.push_front(sym);
            KIND_REM_BACK:
                if (window_syms.size() != 0)
                    void'(window_syms.pop_back());
            KIND_REM_FRONT:
                if (window_syms.size() != 0)
                    void'(window_syms.pop_front());
            KIND_CLEAR:
                window_syms.delete();
            default:
            begin
            end
        endcase
    endtask

    // Half lowercase letters, half any byte.
    function automatic logic [7:0] any_symbol();
        if ($urandom_range(0, 1) != 0)
            return 8'($urandom_range(LOWER_A, LOWER_Z));
        return 8'($urandom_range(0, 255));
    endfunction

    // The symbol that a well-formed removal at this end must name.
    function automatic logic [7:0] present_symbol(input logic [2:0] kind);
        if (window_syms.size() == 0)
            return any_symbol();
        if (kind == KIND_REM_BACK)
            return window_syms[$];
        return window_syms[0];
    endfunction

    // Mostly well-formed edits of a short window, with clears, spare kinds
    // and removals naming the wrong symbol mixed in.
    task automatic plan_random(input int unsigned count);
        int unsigned roll;
        int unsigned grow_pct;
        logic [2:0]  kind;
        for (int unsigned n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                plan_op(KIND_CLEAR, any_symbol());
            else if (roll < 8)
                plan_op(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), any_symbol());
            else if (roll < 13)
                plan_op(3'($urandom_range(KIND_REM_BACK, KIND_REM_FRONT)), any_symbol());
            else
            begin
                if (window_syms.size() < 4)
                    grow_pct = 75;
                else if (window_syms.size() > 40)
                    grow_pct = 25;
                else
                    grow_pct = 50;
                if (window_syms.size() == 0 || $urandom_range(0, 99) < grow_pct)
                    plan_op(3'($urandom_range(KIND_ADD_BACK, KIND_ADD_FRONT)),
                            any_symbol());
                else
                begin
                    kind = 3'($urandom_range(KIND_REM_BACK, KIND_REM_FRONT));
                    plan_op(kind, present_symbol(kind));
                end
            end
        end
    endtask

    // Hold the sender until every queued operation has been answered.
    task automatic drain();
        do
            @(negedge clk);
        while (queued_ops.size() != 0 || push || expected_hashes.size() != 0);
    endtask

    // Driver: on a transfer, predict its result, then present the next
    // operation unless this cycle idles. While full is high, the item is held.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                roll_hashes(item);
                items_sent++;
            end
            if (!(push && full))
            begin
                if (queued_ops.size() != 0
                    && (quiet || $urandom_range(0, 99) >= IDLE_PERCENT))
                begin
                    push <= 1'b1;
                    item <= queued_ops.pop_front();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Monitor: compare each popped result with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : result_check
        out_item_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_hashes.size() == 0)
                begin
                    $error("Unexpected result: hash_first %0d, hash_second %0d, length %0d",
                           result.hash_first, result.hash_second, result.length);
                    mismatches++;
                end
                else
                begin
                    want = expected_hashes.pop_front();
                    results_checked++;
                    if (result.hash_first !== want.hash_first)
                    begin
                        $error("hash_first: expected %0d, actual %0d",
                               want.hash_first, result.hash_first);
                        mismatches++;
                    end
                    if (result.hash_second !== want.hash_second)
                    begin
                        $error("hash_second: expected %0d, actual %0d",
                               want.hash_second, result.hash_second);
                        mismatches++;
                    end
                    if (result.length !== want.length)
                    begin
                        $error("length: expected %0d, actual %0d",
                               want.length, result.length);
                        mismatches++;
                    end
                    if (result.refused !== want.refused)
                    begin
                        $error("refused: expected %0d, actual %0d",
                               want.refused, result.refused);
                        mismatches++;
                    end
                end
            end
            pop <= quiet || $urandom_range(0, 99) >= IDLE_PERCENT;
        end
    end

    // Watchdog: end the run if no transfer happens for too long.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                     stall_cycles, expected_hashes.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        inv_a = pow_mod(RADIX, MOD_A - 2, MOD_A);
        inv_b = pow_mod(RADIX, MOD_B - 2, MOD_B);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: removals on an empty window, symbol extremes at both
        // ends, matching and mismatching removals, spare kinds, clears.
        plan_op(KIND_CLEAR, 8'd0);
        plan_op(KIND_REM_BACK, LOWER_A);
        plan_op(KIND_REM_FRONT, LOWER_Z);
        plan_op(KIND_ADD_BACK, LOWER_A);
        plan_op(KIND_ADD_BACK, 8'd0);
        plan_op(KIND_ADD_FRONT, 8'd255);
        plan_op(KIND_ADD_FRONT, 8'd96);
        plan_op(KIND_ADD_BACK, 8'd95);
        plan_op(KIND_ADD_FRONT, 8'd128);
        plan_op(KIND_REM_BACK, present_symbol(KIND_REM_BACK));
        plan_op(KIND_REM_FRONT, 8'd7);
        plan_op(KIND_SPARE_LO, 8'h55);
        plan_op(3'(KIND_SPARE_LO + 1), 8'hAA);
        plan_op(KIND_SPARE_HI, 8'hFF);
        plan_op(KIND_REM_BACK, 8'd200);
        plan_op(KIND_REM_FRONT, present_symbol(KIND_REM_FRONT));
        plan_op(KIND_CLEAR, 8'd255);
        plan_op(KIND_ADD_FRONT, 8'd98);
        plan_op(KIND_REM_BACK, present_symbol(KIND_REM_BACK));
        plan_op(KIND_ADD_BACK, 8'd99);
        plan_op(KIND_REM_FRONT, present_symbol(KIND_REM_FRONT));
        plan_op(KIND_REM_BACK, 8'd1);
        drain();

        // Random streams; the middle one runs without idling.
        plan_random(600);
        drain();
        quiet = 1'b1;
        plan_random(300);
        drain();
        quiet = 1'b0;
        plan_random(550);
        drain();

        repeat (SETTLE_WAIT) @(negedge clk);
        if (expected_hashes.size() != 0)
        begin
            $error("%0d predicted results never arrived", expected_hashes.size());
            mismatches++;
        end
        $display("Run covered %0d transfers in and %0d results compared, %0d of them refused.",
                 items_sent, results_checked, refusals);
        $display("The window reached %0d symbols; %0d field mismatches were seen.",
                 longest_window, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
